// File: sv/sabr_pkg.sv
// Shared types, constants and helpers for the slip-aligned basis rotation block.
// Used by every module of the block but sabr_delay; depends on nothing.
package sabr_pkg;

  localparam int VEL_W = 32;
  localparam int ROT_W = 32;
  localparam int ROT_N = 9;
  localparam int IDX_W = 10;
  localparam int MAG_W = 33;
  localparam int NORM_W = 30;
  localparam int NORM_MSB = 29;
  localparam int SQRT_W = 31;
  localparam int QW = 31;
  localparam int DIV_NUM_W = 2 * QW - 1;
  localparam logic [30:0] MIN_SLIP_RESET = 31'd66;

  typedef struct packed {
    logic [IDX_W-1:0]        cell_index;
    logic signed [VEL_W-1:0] disp_vel_x;
    logic signed [VEL_W-1:0] disp_vel_y;
    logic signed [VEL_W-1:0] disp_vel_z;
    logic signed [VEL_W-1:0] cont_vel_x;
    logic signed [VEL_W-1:0] cont_vel_y;
    logic signed [VEL_W-1:0] cont_vel_z;
  } sample_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] rot_xx;
    logic signed [ROT_W-1:0] rot_xy;
    logic signed [ROT_W-1:0] rot_xz;
    logic signed [ROT_W-1:0] rot_yx;
    logic signed [ROT_W-1:0] rot_yy;
    logic signed [ROT_W-1:0] rot_yz;
    logic signed [ROT_W-1:0] rot_zx;
    logic signed [ROT_W-1:0] rot_zy;
    logic signed [ROT_W-1:0] rot_zz;
    logic                    updated;
    logic                    degenerate;
  } rot_t;

  typedef logic [ROT_N-1:0][ROT_W-1:0] rot_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [2:0]       neg;
    logic             exceed;
    logic             degen;
  } side_t;

  typedef struct packed {
    side_t                   side;
    logic [2:0][NORM_W-1:0]  nm;
  } side_norm_t;

  typedef struct packed {
    side_t           side;
    logic [QW-1:0]   rn;
  } side_rn_t;

  typedef struct packed {
    side_t               side;
    logic [5:0][QW-1:0]  q;
  } side_quo_t;

  function automatic logic [ROT_W-1:0] signed_bits(logic neg, logic [QW-1:0] mag);
    logic [ROT_W-1:0] v;
    v = ROT_W'(mag);
    return neg ? (ROT_W'(0) - v) : v;
  endfunction

endpackage

// File: sv/sabr_delay.sv
// Enabled shift line that carries side data alongside the arithmetic pipeline.
// Standalone; the optional reset clears the line (used for valid bits).
module sabr_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1,
  parameter bit CLEAR = 1'b0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (CLEAR && rst) begin
      for (int i = 0; i < DEPTH; i++) line[i] <= '0;
    end else if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) line[i] <= line[i-1];
    end
  end

  assign q = line[DEPTH-1];

endmodule

// File: sv/sabr_isqrt.sv
// Pipelined integer square root, one result bit per stage, floor of the root.
// Depends on sabr_pkg for the root width.
module sabr_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [2*sabr_pkg::SQRT_W-1:0] rad,
  output logic [sabr_pkg::SQRT_W-1:0]   root
);

  localparam int W = sabr_pkg::SQRT_W;

  logic [W-1:0]   rt [1:W];
  logic [W+1:0]   rm [1:W];
  logic [2*W-1:0] xs [1:W];

  for (genvar i = 0; i < W; i++) begin : g_step
    logic [W-1:0]   prv_rt;
    logic [W+1:0]   prv_rm;
    logic [2*W-1:0] prv_xs;
    logic [W+3:0]   cur;
    logic [W+3:0]   trial;

    if (i == 0) begin : g_first
      assign prv_rt = '0;
      assign prv_rm = '0;
      assign prv_xs = rad;
    end else begin : g_next
      assign prv_rt = rt[i];
      assign prv_rm = rm[i];
      assign prv_xs = xs[i];
    end

    assign cur = {prv_rm, prv_xs[2*W-1 -: 2]};
    assign trial = {2'b00, prv_rt, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        xs[i+1] <= {prv_xs[2*W-3:0], 2'b00};
        if (cur >= trial) begin
          rm[i+1] <= (W+2)'(cur - trial);
          rt[i+1] <= {prv_rt[W-2:0], 1'b1};
        end else begin
          rm[i+1] <= (W+2)'(cur);
          rt[i+1] <= {prv_rt[W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = rt[W];

endmodule

// File: sv/sabr_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient truncated.
// Depends on sabr_pkg; the numerator's top bits must stay below the divisor.
module sabr_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [sabr_pkg::DIV_NUM_W-1:0] num,
  input  logic [sabr_pkg::QW-1:0]        den,
  output logic [sabr_pkg::QW-1:0]        quo
);

  localparam int Q = sabr_pkg::QW;

  logic [Q-1:0] rm  [1:Q];
  logic [Q-1:0] low [1:Q];
  logic [Q-1:0] qt  [1:Q];
  logic [Q-1:0] dv  [1:Q];

  for (genvar i = 0; i < Q; i++) begin : g_step
    logic [Q-1:0] prv_rm;
    logic [Q-1:0] prv_low;
    logic [Q-1:0] prv_q;
    logic [Q-1:0] prv_dv;
    logic [Q:0]   cur;

    if (i == 0) begin : g_first
      assign prv_rm = Q'(num[sabr_pkg::DIV_NUM_W-1:Q]);
      assign prv_low = num[Q-1:0];
      assign prv_q = '0;
      assign prv_dv = den;
    end else begin : g_next
      assign prv_rm = rm[i];
      assign prv_low = low[i];
      assign prv_q = qt[i];
      assign prv_dv = dv[i];
    end

    assign cur = {prv_rm, prv_low[Q-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        low[i+1] <= {prv_low[Q-2:0], 1'b0};
        dv[i+1] <= prv_dv;
        if (cur >= {1'b0, prv_dv}) begin
          rm[i+1] <= Q'(cur - {1'b0, prv_dv});
          qt[i+1] <= {prv_q[Q-2:0], 1'b1};
        end else begin
          rm[i+1] <= Q'(cur);
          qt[i+1] <= {prv_q[Q-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = qt[Q];

endmodule

// File: sv/sabr_store.sv
// Per-cell tensor memory with a registered read and a clearing pass.
// Depends on sabr_pkg for the tensor word type.
module sabr_store #(
  parameter int CELLS = 1024,
  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [AW-1:0]       addr,
  input  logic                rd_en,
  input  logic                wr_en,
  input  sabr_pkg::rot_word_t wr_data,
  output sabr_pkg::rot_word_t rd_data,
  output logic                clearing
);

  sabr_pkg::rot_word_t mem [CELLS];
  logic [AW-1:0]       clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(CELLS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= AW'(clr_addr + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

// File: sv/slip_aligned_basis_rotation.sv
// Top level of the slip-aligned basis rotation block: slip test, normalization,
// Gram-Schmidt closed forms and the per-cell tensor store.
// Depends on sabr_pkg, sabr_delay, sabr_isqrt, sabr_div and sabr_store.
//
// One item enters per cycle while the result side takes results and no clearing
// pass runs; the pipeline only stalls when the result side holds off. The depth is set by
// the 31-stage square root followed by two chained 31-stage dividers. After
// reset the tensor memory is cleared one cell per cycle, during which no item
// is taken; configuration writes are always taken.
module slip_aligned_basis_rotation #(
  parameter int CELLS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  sabr_pkg::sample_t sample,
  output logic              rot_valid,
  input  logic              rot_ready,
  output sabr_pkg::rot_t    rot,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [30:0]       cfg_min_slip
);

  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int NW = sabr_pkg::NORM_W;
  localparam int QW = sabr_pkg::QW;
  localparam int LAT = 101;

  logic        adv;
  logic        accept;
  logic        clearing;
  logic [30:0] min_slip;
  logic [31:0] thr_base;
  logic [63:0] thr_sq;

  assign adv = !rot_valid || rot_ready;
  assign sample_ready = adv && !clearing;
  assign accept = sample_valid && sample_ready;
  assign cfg_ready = 1'b1;
  assign thr_base = {1'b0, min_slip} + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_slip <= sabr_pkg::MIN_SLIP_RESET;
    end else if (cfg_valid) begin
      min_slip <= cfg_min_slip;
    end
    thr_sq <= thr_base * thr_base;
  end

  // Slip vector.
  logic signed [32:0] slip [3];
  logic [32:0]        mag1 [3];
  logic [2:0]         neg1;
  logic [9:0]         idx1;

  assign slip[0] = 33'(sample.disp_vel_x) - 33'(sample.cont_vel_x);
  assign slip[1] = 33'(sample.disp_vel_y) - 33'(sample.cont_vel_y);
  assign slip[2] = 33'(sample.disp_vel_z) - 33'(sample.cont_vel_z);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        neg1[k] <= slip[k][32];
        mag1[k] <= slip[k][32] ? 33'(-slip[k]) : 33'(slip[k]);
      end
      idx1 <= sample.cell_index;
    end
  end

  // Squares, largest magnitude, overflow of the length test.
  logic [32:0] mmax;
  logic [63:0] sq2 [3];
  logic [32:0] mag2 [3];
  logic [32:0] m2;
  logic [2:0]  neg2;
  logic [9:0]  idx2;
  logic        big2;

  always_comb begin
    mmax = mag1[0];
    if (mag1[1] > mmax) mmax = mag1[1];
    if (mag1[2] > mmax) mmax = mag1[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sq2[k] <= mag1[k][31:0] * mag1[k][31:0];
      end
      big2 <= (mag1[0] > 33'h0_8000_0000) || (mag1[1] > 33'h0_8000_0000) ||
              (mag1[2] > 33'h0_8000_0000);
      m2 <= mmax;
      mag2 <= mag1;
      neg2 <= neg1;
      idx2 <= idx1;
    end
  end

  // Sum of squares and per-byte leading one of the largest magnitude.
  logic [39:0] mpad;
  logic [4:0]  nz;
  logic [2:0]  hi [5];
  logic [63:0] n3;
  logic [4:0]  nz3;
  logic [2:0]  hi3 [5];
  logic [32:0] mag3 [3];
  logic [2:0]  neg3;
  logic [9:0]  idx3;
  logic        big3;

  assign mpad = 40'(m2);

  always_comb begin
    for (int j = 0; j < 5; j++) begin
      nz[j] = |mpad[8*j +: 8];
      hi[j] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (mpad[8*j + b]) hi[j] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n3 <= sq2[0] + sq2[1] + sq2[2];
      nz3 <= nz;
      hi3 <= hi;
      mag3 <= mag2;
      neg3 <= neg2;
      idx3 <= idx2;
      big3 <= big2;
    end
  end

  // Threshold decision and leading-one position.
  logic [5:0]  pos;
  logic [5:0]  pos4;
  logic [32:0] mag4 [3];
  logic [2:0]  neg4;
  logic [9:0]  idx4;
  logic        exc4;

  always_comb begin
    pos = 6'd0;
    for (int j = 0; j < 5; j++) begin
      if (nz3[j]) pos = 6'(8 * j) + {3'b000, hi3[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      exc4 <= big3 || (n3 >= thr_sq);
      pos4 <= pos;
      mag4 <= mag3;
      neg4 <= neg3;
      idx4 <= idx3;
    end
  end

  // Normalization so that the largest magnitude has its top bit at NORM_MSB.
  logic [63:0]           shifted [3];
  logic [2:0][NW-1:0]    nm5;
  logic [2:0]            neg5;
  logic [9:0]            idx5;
  logic                  exc5;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (pos4 > 6'(sabr_pkg::NORM_MSB)) begin
        shifted[k] = 64'(mag4[k]) >> (pos4 - 6'(sabr_pkg::NORM_MSB));
      end else begin
        shifted[k] = 64'(mag4[k]) << (6'(sabr_pkg::NORM_MSB) - pos4);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) nm5[k] <= shifted[k][NW-1:0];
      neg5 <= neg4;
      idx5 <= idx4;
      exc5 <= exc4;
    end
  end

  // Squares of the normalized components.
  logic [2*NW-1:0]    nsq6 [3];
  logic [2:0][NW-1:0] nm6;
  sabr_pkg::side_t    side6;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) nsq6[k] <= nm5[k] * nm5[k];
      nm6 <= nm5;
      side6.idx <= idx5;
      side6.neg <= neg5;
      side6.exceed <= exc5;
      side6.degen <= exc5 && (nm5[0] == '0);
    end
  end

  logic [2*sabr_pkg::SQRT_W-1:0] nn7;
  logic [2*sabr_pkg::SQRT_W-1:0] p7;
  sabr_pkg::side_norm_t          sn7;

  always_ff @(posedge clk) begin
    if (adv) begin
      nn7 <= 62'(nsq6[0]) + 62'(nsq6[1]) + 62'(nsq6[2]);
      p7 <= 62'(nsq6[0]) + 62'(nsq6[2]);
      sn7.side <= side6;
      sn7.nm <= nm6;
    end
  end

  // Square roots of the full and the x-z norms.
  logic [QW-1:0]        rn38;
  logic [QW-1:0]        rp38;
  sabr_pkg::side_norm_t sn38;

  sabr_isqrt u_sqrt_n (.clk(clk), .en(adv), .rad(nn7), .root(rn38));
  sabr_isqrt u_sqrt_p (.clk(clk), .en(adv), .rad(p7), .root(rp38));

  sabr_delay #(.WIDTH($bits(sabr_pkg::side_norm_t)), .DEPTH(sabr_pkg::SQRT_W), .CLEAR(1'b0))
    u_dly_norm (.clk(clk), .rst(rst), .en(adv), .d(sn7), .q(sn38));

  logic [2*NW-1:0]    ab39;
  logic [2*NW-1:0]    bc39;
  logic [QW-1:0]      rn39;
  logic [QW-1:0]      rp39;
  logic [2:0][NW-1:0] nm39;
  sabr_pkg::side_t    side39;

  always_ff @(posedge clk) begin
    if (adv) begin
      ab39 <= sn38.nm[0] * sn38.nm[1];
      bc39 <= sn38.nm[1] * sn38.nm[2];
      rn39 <= rn38;
      rp39 <= rp38;
      nm39 <= sn38.nm;
      side39 <= sn38.side;
    end
  end

  // First division level.
  logic [QW-1:0] q_a_rn, q_b_rn, q_c_rn, q_rp_rn, q_ab_rp, q_bc_rp, q_c_rp, q_a_rp;

  sabr_div u_div_a_rn (.clk(clk), .en(adv), .num({1'b0, nm39[0], 30'd0}), .den(rn39),
                       .quo(q_a_rn));
  sabr_div u_div_b_rn (.clk(clk), .en(adv), .num({1'b0, nm39[1], 30'd0}), .den(rn39),
                       .quo(q_b_rn));
  sabr_div u_div_c_rn (.clk(clk), .en(adv), .num({1'b0, nm39[2], 30'd0}), .den(rn39),
                       .quo(q_c_rn));
  sabr_div u_div_rp_rn (.clk(clk), .en(adv), .num({rp39, 30'd0}), .den(rn39),
                        .quo(q_rp_rn));
  sabr_div u_div_ab_rp (.clk(clk), .en(adv), .num({1'b0, ab39}), .den(rp39),
                        .quo(q_ab_rp));
  sabr_div u_div_bc_rp (.clk(clk), .en(adv), .num({1'b0, bc39}), .den(rp39),
                        .quo(q_bc_rp));
  sabr_div u_div_c_rp (.clk(clk), .en(adv), .num({1'b0, nm39[2], 30'd0}), .den(rp39),
                       .quo(q_c_rp));
  sabr_div u_div_a_rp (.clk(clk), .en(adv), .num({1'b0, nm39[0], 30'd0}), .den(rp39),
                       .quo(q_a_rp));

  sabr_pkg::side_rn_t srn39;
  sabr_pkg::side_rn_t srn70;

  assign srn39.side = side39;
  assign srn39.rn = rn39;

  sabr_delay #(.WIDTH($bits(sabr_pkg::side_rn_t)), .DEPTH(QW), .CLEAR(1'b0))
    u_dly_rn (.clk(clk), .rst(rst), .en(adv), .d(srn39), .q(srn70));

  // Second division level for the off-diagonal terms of the second axis.
  logic [QW-1:0]       q2_ab;
  logic [QW-1:0]       q2_bc;
  sabr_pkg::side_quo_t sq70;
  sabr_pkg::side_quo_t sq101;

  sabr_div u_div2_ab (.clk(clk), .en(adv), .num({q_ab_rp, 30'd0}), .den(srn70.rn),
                      .quo(q2_ab));
  sabr_div u_div2_bc (.clk(clk), .en(adv), .num({q_bc_rp, 30'd0}), .den(srn70.rn),
                      .quo(q2_bc));

  assign sq70.side = srn70.side;
  assign sq70.q = {q_a_rp, q_c_rp, q_rp_rn, q_c_rn, q_b_rn, q_a_rn};

  sabr_delay #(.WIDTH($bits(sabr_pkg::side_quo_t)), .DEPTH(QW), .CLEAR(1'b0))
    u_dly_quo (.clk(clk), .rst(rst), .en(adv), .d(sq70), .q(sq101));

  logic v101;

  sabr_delay #(.WIDTH(1), .DEPTH(LAT), .CLEAR(1'b1))
    u_dly_valid (.clk(clk), .rst(rst), .en(adv), .d(accept), .q(v101));

  // Tensor assembly and memory access.
  sabr_pkg::rot_word_t tens;
  logic [20:0]         idx_ext;
  logic                in_range;
  logic                upd;
  logic                wr_en;
  logic [2:0]          ng;
  sabr_pkg::rot_word_t rd_data;

  assign ng = sq101.side.neg;
  assign idx_ext = 21'(sq101.side.idx);
  assign in_range = idx_ext < 21'(CELLS);
  assign upd = sq101.side.exceed && !sq101.side.degen;
  assign wr_en = adv && v101 && upd && in_range;

  always_comb begin
    tens[0] = sabr_pkg::signed_bits(ng[0], sq101.q[0]);
    tens[3] = sabr_pkg::signed_bits(ng[1], sq101.q[1]);
    tens[6] = sabr_pkg::signed_bits(ng[2], sq101.q[2]);
    tens[1] = sabr_pkg::signed_bits(ng[0] == ng[1], q2_ab);
    tens[4] = sabr_pkg::signed_bits(1'b0, sq101.q[3]);
    tens[7] = sabr_pkg::signed_bits(ng[1] == ng[2], q2_bc);
    tens[2] = sabr_pkg::signed_bits(ng[0] == ng[2], sq101.q[4]);
    tens[5] = '0;
    tens[8] = sabr_pkg::signed_bits(1'b0, sq101.q[5]);
  end

  sabr_store #(.CELLS(CELLS)) u_store (
    .clk(clk),
    .rst(rst),
    .addr(idx_ext[AW-1:0]),
    .rd_en(adv),
    .wr_en(wr_en),
    .wr_data(tens),
    .rd_data(rd_data),
    .clearing(clearing)
  );

  // Result register.
  sabr_pkg::rot_word_t tens_q;
  sabr_pkg::rot_word_t outw;
  logic                upd_q;
  logic                deg_q;
  logic                inr_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_valid <= 1'b0;
    end else if (adv) begin
      rot_valid <= v101;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tens_q <= tens;
      upd_q <= upd;
      deg_q <= sq101.side.degen;
      inr_q <= in_range;
    end
  end

  assign outw = upd_q ? tens_q : (inr_q ? rd_data : '0);

  assign rot.rot_xx = outw[0];
  assign rot.rot_xy = outw[1];
  assign rot.rot_xz = outw[2];
  assign rot.rot_yx = outw[3];
  assign rot.rot_yy = outw[4];
  assign rot.rot_yz = outw[5];
  assign rot.rot_zx = outw[6];
  assign rot.rot_zy = outw[7];
  assign rot.rot_zz = outw[8];
  assign rot.updated = upd_q;
  assign rot.degenerate = deg_q;

  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !sample_ready)
    else $error("Item taken during the clearing pass.");

  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !clearing)
    else $error("Tensor write collides with the clearing pass.");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rot_valid |-> !(rot.updated && rot.degenerate))
    else $error("Result is both updated and degenerate.");

  a_new_tensor_shape: assert property (@(posedge clk) disable iff (rst)
    rot_valid && rot.updated |-> rot.rot_yz == 32'sd0 && !rot.rot_zz[31] && !rot.rot_yy[31])
    else $error("New tensor breaks the basis shape.");

endmodule

// File: bench/slip_aligned_basis_rotation_test.sv
// Self-checking testbench for slip_aligned_basis_rotation: drives cells with valid/ready
// and random idling, predicts each rotation tensor in a scoreboard class and compares.
// Depends on sabr_pkg and the slip_aligned_basis_rotation RTL.
module slip_aligned_basis_rotation_test;

  localparam int NCELLS = 1024;
  localparam int SETTLE_CYCLES = 130;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  class rotation_scoreboard;
    bit [30:0] min_slip;
    bit [31:0] held[NCELLS][9];
    sabr_pkg::rot_t tensor_q[$];
    int errors;

    function new();
      min_slip = sabr_pkg::MIN_SLIP_RESET;
      errors = 0;
      foreach (held[c, k]) held[c][k] = '0;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned qdiv(longint unsigned num, longint unsigned den);
      return (den == 0) ? 64'd0 : (num << 30) / den;
    endfunction

    function logic [31:0] with_sign(bit ng, longint unsigned mag);
      return ng ? 32'(64'd0 - mag) : 32'(mag);
    endfunction

    function void note_sample(sabr_pkg::sample_t s);
      logic signed [31:0] dv[3];
      logic signed [31:0] cv[3];
      longint unsigned m[3];
      bit ng[3];
      longint signed d;
      longint unsigned mx, a, b, c, nn, p, rn, rp;
      bit big, upd, degen;
      logic [31:0] w[9];
      sabr_pkg::rot_t r;
      dv[0] = s.disp_vel_x; dv[1] = s.disp_vel_y; dv[2] = s.disp_vel_z;
      cv[0] = s.cont_vel_x; cv[1] = s.cont_vel_y; cv[2] = s.cont_vel_z;
      big = 0;
      upd = 0;
      degen = 0;
      for (int k = 0; k < 3; k++) begin
        d = longint'(dv[k]) - longint'(cv[k]);
        ng[k] = d < 0;
        m[k] = ng[k] ? longint'(-d) : longint'(d);
        if (m[k] > (64'd1 << 31)) big = 1;
      end
      if (!big) big = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]) > min_slip;
      if (big) begin
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        while (mx >= ONE_Q30) begin
          mx >>= 1;
          for (int k = 0; k < 3; k++) m[k] >>= 1;
        end
        while (mx != 0 && mx < (ONE_Q30 >> 1)) begin
          mx <<= 1;
          for (int k = 0; k < 3; k++) m[k] <<= 1;
        end
        a = m[0]; b = m[1]; c = m[2];
        nn = a * a + b * b + c * c;
        p = a * a + c * c;
        if (p == 0 || a == 0 || nn == 0) begin
          degen = 1;
        end else begin
          rn = root_floor(nn);
          rp = root_floor(p);
          w[0] = with_sign(ng[0], qdiv(a, rn));
          w[3] = with_sign(ng[1], qdiv(b, rn));
          w[6] = with_sign(ng[2], qdiv(c, rn));
          w[1] = with_sign(ng[0] == ng[1], qdiv(a * b / rp, rn));
          w[4] = with_sign(0, qdiv(rp, rn));
          w[7] = with_sign(ng[1] == ng[2], qdiv(b * c / rp, rn));
          w[2] = with_sign(ng[0] == ng[2], qdiv(c, rp));
          w[5] = '0;
          w[8] = with_sign(0, qdiv(a, rp));
          upd = 1;
          for (int k = 0; k < 9; k++) held[s.cell_index][k] = w[k];
        end
      end
      if (!upd) for (int k = 0; k < 9; k++) w[k] = held[s.cell_index][k];
      r.rot_xx = w[0]; r.rot_xy = w[1]; r.rot_xz = w[2];
      r.rot_yx = w[3]; r.rot_yy = w[4]; r.rot_yz = w[5];
      r.rot_zx = w[6]; r.rot_zy = w[7]; r.rot_zz = w[8];
      r.updated = upd;
      r.degenerate = degen;
      tensor_q.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_rot(sabr_pkg::rot_t got);
      sabr_pkg::rot_t want;
      if (tensor_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = tensor_q.pop_front();
      compare("rot_xx", want.rot_xx, got.rot_xx);
      compare("rot_xy", want.rot_xy, got.rot_xy);
      compare("rot_xz", want.rot_xz, got.rot_xz);
      compare("rot_yx", want.rot_yx, got.rot_yx);
      compare("rot_yy", want.rot_yy, got.rot_yy);
      compare("rot_yz", want.rot_yz, got.rot_yz);
      compare("rot_zx", want.rot_zx, got.rot_zx);
      compare("rot_zy", want.rot_zy, got.rot_zy);
      compare("rot_zz", want.rot_zz, got.rot_zz);
      compare("updated", 32'(want.updated), 32'(got.updated));
      compare("degenerate", 32'(want.degenerate), 32'(got.degenerate));
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic sample_valid = 0;
  logic sample_ready;
  sabr_pkg::sample_t sample = '0;
  logic rot_valid;
  logic rot_ready = 0;
  sabr_pkg::rot_t rot;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [30:0] cfg_min_slip = '0;

  rotation_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int cycles = 0;

  slip_aligned_basis_rotation #(.CELLS(NCELLS)) u_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
    .rot_valid(rot_valid), .rot_ready(rot_ready), .rot(rot),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_min_slip(cfg_min_slip)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("slip_aligned_basis_rotation regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rot_ready <= 0;
    end else begin
      rot_ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rot_valid && rot_ready) sb.check_rot(rot);
  end

  task automatic send_cell(sabr_pkg::sample_t s);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_valid <= 0;
      @(negedge clk);
    end
    sample_valid <= 1;
    sample <= s;
    do @(posedge clk); while (!sample_ready);
    sb.note_sample(s);
  endtask

  task automatic write_min_slip(logic [30:0] v);
    @(negedge clk);
    sample_valid <= 0;
    cfg_valid <= 1;
    cfg_min_slip <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.min_slip = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    @(negedge clk);
    sample_valid <= 0;
    while (sb.tensor_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sabr_pkg::sample_t make_cell(int idx, int dx, int dy, int dz,
                                                  int cx, int cy, int cz);
    sabr_pkg::sample_t s;
    s.cell_index = idx[9:0];
    s.disp_vel_x = dx; s.disp_vel_y = dy; s.disp_vel_z = dz;
    s.cont_vel_x = cx; s.cont_vel_y = cy; s.cont_vel_z = cz;
    return s;
  endfunction

  function automatic int rand_slip();
    int sh;
    sh = $urandom_range(0, 31);
    return int'($urandom()) >>> sh;
  endfunction

  function automatic sabr_pkg::sample_t random_cell();
    sabr_pkg::sample_t s;
    int sx, sy, sz, kind;
    s.cell_index = ($urandom_range(0, 3) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 15));
    s.cont_vel_x = $urandom(); s.cont_vel_y = $urandom(); s.cont_vel_z = $urandom();
    kind = $urandom_range(0, 9);
    sx = rand_slip(); sy = rand_slip(); sz = rand_slip();
    case (kind)
      0: begin
        sx = 0;
      end
      1: begin
        sx = 0;
        sz = 0;
      end
      2: begin
        sx = int'(sb.min_slip) + $urandom_range(0, 2) - 1;
        sy = 0;
        sz = 0;
      end
      3: begin
        sx = 0; sy = 0; sz = 0;
      end
      default: ;
    endcase
    if (kind == 9) begin
      s.disp_vel_x = $urandom(); s.disp_vel_y = $urandom(); s.disp_vel_z = $urandom();
    end else begin
      s.disp_vel_x = s.cont_vel_x + sx;
      s.disp_vel_y = s.cont_vel_y + sy;
      s.disp_vel_z = s.cont_vel_z + sz;
    end
    return s;
  endfunction

  initial begin
    sabr_pkg::sample_t directed[$];
    logic [30:0] slip_setting[4];
    int recv_pct[4];
    int send_pct[4];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    slip_setting[0] = 31'd66;
    slip_setting[1] = 31'h7FFF_FFFF;
    slip_setting[2] = 31'd0;
    slip_setting[3] = 31'($urandom_range(1, 1 << 20));
    send_pct = '{25, 83, 0, 0};
    recv_pct = '{83, 25, 0, 0};

    directed.push_back(make_cell(0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_cell(1, 66, 0, 0, 0, 0, 0));
    directed.push_back(make_cell(1, 67, 0, 0, 0, 0, 0));
    directed.push_back(make_cell(2, 1 << 16, 0, 0, 0, 0, 0));
    directed.push_back(make_cell(2, 5, 0, 0, 5, 0, 0));
    directed.push_back(make_cell(2, 0, 3 << 16, 0, 0, 0, 0));
    directed.push_back(make_cell(2, 0, 5 << 16, -7 << 16, 0, 0, 0));
    directed.push_back(make_cell(3, -3 << 16, -5 << 16, -7 << 16, 0, 0, 0));
    directed.push_back(make_cell(1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    directed.push_back(make_cell(1022, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    directed.push_back(make_cell(4, 32'h8000_0000, 0, 0, 0, 0, 0));
    directed.push_back(make_cell(5, 1 << 16, -1 << 16, 1 << 16, 0, 0, 0));
    directed.push_back(make_cell(6, -1 << 16, 1 << 16, -1 << 16, 0, 0, 0));
    directed.push_back(make_cell(7, 1, 1, 1, 0, 0, 0));
    directed.push_back(make_cell(5, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_cell(1023, 9, 9, 9, 9, 9, 9));
    directed.push_back(make_cell(8, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0));

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      write_min_slip(slip_setting[ph]);
      if (ph == 0) foreach (directed[i]) send_cell(directed[i]);
      for (int i = 0; i < 160; i++) begin
        if (ph == 2 && i == 20) hold_left = 400;
        send_cell(random_cell());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("slip_aligned_basis_rotation regression: pass");
    end else begin
      $display("slip_aligned_basis_rotation regression: fail");
    end
    $finish;
  end
endmodule

// File: sim.f
sv/sabr_pkg.sv
sv/sabr_delay.sv
sv/sabr_isqrt.sv
sv/sabr_div.sv
sv/sabr_store.sv
sv/slip_aligned_basis_rotation.sv
bench/slip_aligned_basis_rotation_test.sv
